### design/wlrc_pkg.sv
`timescale 1ns / 1ps

package wlrc_pkg;

   // light state codes, shared by the controller and the port checker
   typedef enum logic [2:0] {
      MODE_IDLE   = 3'd0,
      MODE_ON     = 3'd1,
      MODE_RAMP   = 3'd2,
      MODE_RETURN = 3'd3,
      MODE_SETTLE = 3'd4
   } light_state_type;

   // sleep stage codes
   localparam logic [1:0] STAGE_UNKNOWN = 2'd0;
   localparam logic [1:0] STAGE_WAKE    = 2'd1;
   localparam logic [1:0] STAGE_NREM    = 2'd2;
   localparam logic [1:0] STAGE_REM     = 2'd3;

   // register indexes
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_HIGH_THRESHOLD = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LOW_THRESHOLD  = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_START_LEVEL    = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_STEP           = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CEILING        = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RAMP_INTERVAL  = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SETTLE_COUNT   = 3'd6;

   // register reset values
   localparam logic [11:0] RESET_HIGH_THRESHOLD = 12'd320;  // 20.0 in Q8.4
   localparam logic [11:0] RESET_LOW_THRESHOLD  = 12'd80;   // 5.0 in Q8.4
   localparam logic [7:0]  RESET_START_LEVEL    = 8'd20;
   localparam logic [7:0]  RESET_STEP           = 8'd5;
   localparam logic [7:0]  RESET_CEILING        = 8'd80;
   localparam logic [15:0] RESET_RAMP_INTERVAL  = 16'd30;
   localparam logic [7:0]  RESET_SETTLE_COUNT   = 8'd2;

   localparam logic [7:0] COUNT_MAX = 8'hFF;

   typedef struct packed {
      logic [11:0] high_motion_threshold;
      logic [11:0] low_motion_threshold;
      logic [7:0]  start_brightness;
      logic [7:0]  brightness_step;
      logic [7:0]  brightness_ceiling;
      logic [15:0] ramp_interval;
      logic [7:0]  settle_epoch_count;
   } cfg_type;

   typedef struct packed {
      logic [1:0]  sleep_stage;
      logic        monitoring_mode;
      logic [11:0] motion_level;
      logic [31:0] time_seconds;
   } req_type;

   typedef struct packed {
      logic [7:0] brightness;
      logic [2:0] light_state;
      logic       backlight_write;
   } rsp_type;

endpackage

### design/wlrc_csr.sv
`timescale 1ns / 1ps

module wlrc_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_write_enable,
   input  logic [wlrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wlrc_pkg::CSR_DATA_BITS-1:0]  csr_write_data,
   output wlrc_pkg::cfg_type                   cfg
);
   import wlrc_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         // unknown indexes fall through with no effect
         unique case (csr_index)
            CSR_HIGH_THRESHOLD: cfg_in.high_motion_threshold = csr_write_data[11:0];
            CSR_LOW_THRESHOLD:  cfg_in.low_motion_threshold  = csr_write_data[11:0];
            CSR_START_LEVEL:    cfg_in.start_brightness      = csr_write_data[7:0];
            CSR_STEP:           cfg_in.brightness_step       = csr_write_data[7:0];
            CSR_CEILING:        cfg_in.brightness_ceiling    = csr_write_data[7:0];
            CSR_RAMP_INTERVAL:  cfg_in.ramp_interval         = csr_write_data;
            CSR_SETTLE_COUNT:   cfg_in.settle_epoch_count    = csr_write_data[7:0];
            default:            cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.high_motion_threshold <= RESET_HIGH_THRESHOLD;
         cfg_ff.low_motion_threshold  <= RESET_LOW_THRESHOLD;
         cfg_ff.start_brightness      <= RESET_START_LEVEL;
         cfg_ff.brightness_step       <= RESET_STEP;
         cfg_ff.brightness_ceiling    <= RESET_CEILING;
         cfg_ff.ramp_interval         <= RESET_RAMP_INTERVAL;
         cfg_ff.settle_epoch_count    <= RESET_SETTLE_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

### design/wake_light_ramp_controller.sv
`timescale 1ns / 1ps

// wake light ramp controller
//
// req channel: one sleep-tracking epoch per transfer (stage, monitoring flag,
// motion level in Q8.4, timestamp in seconds). rsp channel: one result per
// epoch with the light brightness, the light state and a flag that is set
// when the epoch sent a new level to the light.
// csr port: plain write port, one register per write, no read-back; write
// it only while no epoch is in flight.
//
// latency: the result of an epoch is valid the cycle after its req transfer.
// throughput: one epoch per cycle while the result is not stalled; the next-state
// logic sits between the state registers and the single result register, so a
// new epoch can be taken every cycle while rsp_ready is high.
// stall: req_ready stays high while the result register is empty or is being
// drained this cycle; when rsp_ready is held low the result holds and
// req_ready drops until it is taken.
// reset: synchronous, clears the light state machine, counters and result
// valid flag and loads the register defaults.
module wake_light_ramp_controller #(
   parameter int TIME_BITS = 32
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  wlrc_pkg::req_type                   req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output wlrc_pkg::rsp_type                   rsp_data,
   input  logic                                csr_write_enable,
   input  logic [wlrc_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [wlrc_pkg::CSR_DATA_BITS-1:0]  csr_write_data
);
   import wlrc_pkg::*;

   localparam int WIDE_BITS = (TIME_BITS > 32) ? TIME_BITS : 32;
   localparam int CMP_BITS  = (TIME_BITS > 16) ? TIME_BITS : 16;

   cfg_type cfg;

   wlrc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .cfg              (cfg)
   );

   // epoch state
   light_state_type       mode_ff, mode_in;
   logic [7:0]            level_ff, level_in;
   logic [TIME_BITS-1:0]  last_ramp_ff, last_ramp_in;
   logic [1:0]            prev_stage_ff;
   logic                  prev_high_ff;
   logic [7:0]            rise_count_ff, rise_count_in;
   logic [7:0]            quiet_ff, quiet_in;

   // result register
   rsp_type               rsp_ff;
   logic                  rsp_valid_ff;

   logic                  req_fire;
   logic [WIDE_BITS-1:0]  time_wide;
   logic [TIME_BITS-1:0]  now;
   logic [TIME_BITS-1:0]  elapsed;
   logic                  high, low, rise, woke;
   logic                  ramp_due;
   logic [8:0]            ramp_sum;
   logic [7:0]            ramp_level;
   logic                  write;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // timestamp taken modulo 2^TIME_BITS
   assign time_wide = WIDE_BITS'(req_data.time_seconds);
   assign now       = time_wide[TIME_BITS-1:0];
   assign elapsed   = now - last_ramp_ff;

   // motion classification and edge detect
   assign high = req_data.motion_level > cfg.high_motion_threshold;
   assign low  = req_data.motion_level < cfg.low_motion_threshold;
   assign rise = !prev_high_ff && high;
   assign woke = (prev_stage_ff == STAGE_NREM || prev_stage_ff == STAGE_REM)
                 && req_data.sleep_stage == STAGE_WAKE;

   // ramp step, summed one bit wider and clamped to the ceiling
   assign ramp_due = (CMP_BITS'(elapsed) >= CMP_BITS'(cfg.ramp_interval))
                     && (level_ff < cfg.brightness_ceiling);
   assign ramp_sum   = {1'b0, level_ff} + {1'b0, cfg.brightness_step};
   assign ramp_level = (ramp_sum > {1'b0, cfg.brightness_ceiling}) ?
                       cfg.brightness_ceiling : ramp_sum[7:0];

   always_comb begin
      // saturating counters, updated before the state decision
      rise_count_in = rise_count_ff;
      if (rise && rise_count_ff != COUNT_MAX) begin
         rise_count_in = rise_count_ff + 8'd1;
      end
      if (low) begin
         quiet_in = (quiet_ff != COUNT_MAX) ? quiet_ff + 8'd1 : quiet_ff;
      end else begin
         quiet_in = 8'd0;
      end

      mode_in      = mode_ff;
      level_in     = level_ff;
      last_ramp_in = last_ramp_ff;
      write        = 1'b0;

      unique case (mode_ff)
         MODE_IDLE: begin
            // light on when waking or monitoring lines up with a motion rise
            if ((woke || req_data.monitoring_mode) && rise) begin
               mode_in       = MODE_ON;
               level_in      = cfg.start_brightness;
               last_ramp_in  = now;
               rise_count_in = 8'd1;
               write         = 1'b1;
            end
         end
         MODE_ON: begin
            mode_in = MODE_RAMP;
         end
         MODE_RAMP: begin
            if (ramp_due) begin
               level_in     = ramp_level;
               last_ramp_in = now;
               write        = 1'b1;
            end
            if (low) begin
               mode_in = MODE_RETURN;
            end
         end
         MODE_RETURN: begin
            if (ramp_due) begin
               level_in     = ramp_level;
               last_ramp_in = now;
               write        = 1'b1;
            end
            // user came back: a second rise since turn-on
            if (rise && rise_count_in >= 8'd2) begin
               mode_in  = MODE_SETTLE;
               quiet_in = 8'd0;
            end
         end
         MODE_SETTLE: begin
            if (quiet_in >= cfg.settle_epoch_count) begin
               mode_in       = MODE_IDLE;
               level_in      = 8'd0;
               rise_count_in = 8'd0;
               quiet_in      = 8'd0;
               write         = 1'b1;
            end
         end
         default: begin
            // unreachable codes drop back to idle without a write
            mode_in = MODE_IDLE;
         end
      endcase
   end

   // state and result payload advance only on a req transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_IDLE;
         level_ff      <= 8'd0;
         last_ramp_ff  <= '0;
         prev_stage_ff <= STAGE_UNKNOWN;
         prev_high_ff  <= 1'b0;
         rise_count_ff <= 8'd0;
         quiet_ff      <= 8'd0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (req_fire) begin
            mode_ff                <= mode_in;
            level_ff               <= level_in;
            last_ramp_ff           <= last_ramp_in;
            prev_stage_ff          <= req_data.sleep_stage;
            prev_high_ff           <= high;
            rise_count_ff          <= rise_count_in;
            quiet_ff               <= quiet_in;
            rsp_ff.brightness      <= level_in;
            rsp_ff.light_state     <= mode_in;
            rsp_ff.backlight_write <= write;
         end
         rsp_valid_ff <= req_fire || (rsp_valid_ff && !rsp_ready);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### design/wlrc_checker.sv
`timescale 1ns / 1ps

module wlrc_checker (
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_ready,
   input logic              rsp_valid,
   input logic              rsp_ready,
   input wlrc_pkg::rsp_type rsp_data
);
   import wlrc_pkg::*;

   // every req transfer yields a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> rsp_valid)
      else $error("req transfer without a result on the next cycle");

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result changed");

   // result register full and not drained blocks new epochs
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |-> !req_ready)
      else $error("req taken while result is stalled");

   // the light is dark whenever the controller reports idle
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.light_state == MODE_IDLE) |-> (rsp_data.brightness == 8'd0))
      else $error("idle result with nonzero brightness");

endmodule

bind wake_light_ramp_controller wlrc_checker u_wlrc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

### tb/tb_wake_light_ramp_controller.sv
`timescale 1ns / 1ps

module tb_wake_light_ramp_controller;
   import wlrc_pkg::*;

   // generous bound: every epoch waiting out the longest gaps and stalls,
   // plus the receiver hold-offs, taken several times over
   localparam int CYCLE_LIMIT     = 200000;
   localparam int HOLD_OFF_CYCLES = 60;
   localparam int PHASE_EPOCHS    = 160;
   localparam int PHASE_COUNT     = 8;

   // how an epoch's motion sits against the current thresholds
   typedef enum {MOTION_LOW, MOTION_MID, MOTION_HIGH, MOTION_ANY} motion_kind_type;

   // own copy of the controller: registers, state machine, counters and the
   // lights expected back, oldest first
   class light_scoreboard;
      cfg_type         regs;
      light_state_type mode;
      logic [7:0]      level;
      logic [31:0]     last_ramp_time;
      logic [1:0]      prev_stage;
      logic            prev_high;
      logic [7:0]      rise_count;
      logic [7:0]      quiet_epochs;
      rsp_type         expected_lights[$];
      int              mismatches;

      function new();
         regs.high_motion_threshold = RESET_HIGH_THRESHOLD;
         regs.low_motion_threshold  = RESET_LOW_THRESHOLD;
         regs.start_brightness      = RESET_START_LEVEL;
         regs.brightness_step       = RESET_STEP;
         regs.brightness_ceiling    = RESET_CEILING;
         regs.ramp_interval         = RESET_RAMP_INTERVAL;
         regs.settle_epoch_count    = RESET_SETTLE_COUNT;
         mode           = MODE_IDLE;
         level          = '0;
         last_ramp_time = '0;
         prev_stage     = STAGE_UNKNOWN;
         prev_high      = 1'b0;
         rise_count     = '0;
         quiet_epochs   = '0;
         mismatches     = 0;
      endfunction

      function void set_register(logic [CSR_INDEX_BITS-1:0] index,
                                 logic [CSR_DATA_BITS-1:0] data);
         case (index)
            CSR_HIGH_THRESHOLD: regs.high_motion_threshold = data[11:0];
            CSR_LOW_THRESHOLD:  regs.low_motion_threshold  = data[11:0];
            CSR_START_LEVEL:    regs.start_brightness      = data[7:0];
            CSR_STEP:           regs.brightness_step       = data[7:0];
            CSR_CEILING:        regs.brightness_ceiling    = data[7:0];
            CSR_RAMP_INTERVAL:  regs.ramp_interval         = data;
            CSR_SETTLE_COUNT:   regs.settle_epoch_count    = data[7:0];
            default: ;
         endcase
      endfunction

      // one brightness step when the interval has run out and there is headroom
      function bit advance_ramp(logic [31:0] now);
         logic [31:0] elapsed;
         logic [8:0]  sum;
         elapsed = now - last_ramp_time;
         if (elapsed >= 32'(regs.ramp_interval) && level < regs.brightness_ceiling) begin
            sum = {1'b0, level} + {1'b0, regs.brightness_step};
            if (sum > {1'b0, regs.brightness_ceiling})
               sum = {1'b0, regs.brightness_ceiling};
            level          = sum[7:0];
            last_ramp_time = now;
            return 1'b1;
         end
         return 1'b0;
      endfunction

      function void note_epoch(req_type epoch);
         logic    high_motion;
         logic    low_motion;
         logic    rise;
         logic    woke;
         logic    wrote;
         rsp_type light;
         high_motion = epoch.motion_level > regs.high_motion_threshold;
         low_motion  = epoch.motion_level < regs.low_motion_threshold;
         rise        = !prev_high && high_motion;
         wrote       = 1'b0;
         if (rise && rise_count != COUNT_MAX)
            rise_count++;
         if (low_motion) begin
            if (quiet_epochs != COUNT_MAX)
               quiet_epochs++;
         end else begin
            quiet_epochs = '0;
         end
         case (mode)
            MODE_IDLE: begin
               woke = (prev_stage == STAGE_NREM || prev_stage == STAGE_REM) &&
                      epoch.sleep_stage == STAGE_WAKE;
               if ((woke || epoch.monitoring_mode) && rise) begin
                  mode           = MODE_ON;
                  level          = regs.start_brightness;
                  last_ramp_time = epoch.time_seconds;
                  rise_count     = 8'd1;
                  wrote          = 1'b1;
               end
            end
            MODE_ON: mode = MODE_RAMP;
            MODE_RAMP: begin
               wrote = advance_ramp(epoch.time_seconds);
               if (low_motion)
                  mode = MODE_RETURN;
            end
            MODE_RETURN: begin
               wrote = advance_ramp(epoch.time_seconds);
               if (rise && rise_count >= 8'd2) begin
                  mode         = MODE_SETTLE;
                  quiet_epochs = '0;
               end
            end
            MODE_SETTLE: begin
               if (quiet_epochs >= regs.settle_epoch_count) begin
                  mode         = MODE_IDLE;
                  level        = '0;
                  rise_count   = '0;
                  quiet_epochs = '0;
                  wrote        = 1'b1;
               end
            end
            default: mode = MODE_IDLE;
         endcase
         prev_stage = epoch.sleep_stage;
         prev_high  = high_motion;
         light.brightness      = level;
         light.light_state     = mode;
         light.backlight_write = wrote;
         expected_lights.push_back(light);
      endfunction

      function void check_light(rsp_type got);
         rsp_type want;
         if (expected_lights.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("%0t: unexpected light: level %0d state %0d write %0b",
                        $time, got.brightness, got.light_state, got.backlight_write);
            return;
         end
         want = expected_lights.pop_front();
         if (got.brightness !== want.brightness || got.light_state !== want.light_state ||
             got.backlight_write !== want.backlight_write) begin
            mismatches++;
            if (mismatches <= 10)
               $display({"%0t: light mismatch: expected level %0d state %0d write %0b, ",
                         "got %0d %0d %0b"},
                        $time, want.brightness, want.light_state, want.backlight_write,
                        got.brightness, got.light_state, got.backlight_write);
         end
      endfunction

      function int pending();
         return expected_lights.size();
      endfunction
   endclass

   logic                      clock            = 1'b0;
   logic                      reset            = 1'b1;
   logic                      req_valid        = 1'b0;
   logic                      req_ready;
   req_type                   req_data         = '0;
   logic                      rsp_valid;
   logic                      rsp_ready        = 1'b0;
   rsp_type                   rsp_data;
   logic                      csr_write_enable = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index        = '0;
   logic [CSR_DATA_BITS-1:0]  csr_write_data   = '0;

   light_scoreboard board;
   cfg_type         settings;        // register values the stimulus is shaped around
   logic [31:0]     epoch_time = '0;
   bit              burst = 1'b0;    // no random gaps or random stalls on either side while set
   bit              hold_request = 1'b0;
   int              epochs_sent = 0;
   int              cycle_count = 0;

   wake_light_ramp_controller uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data         (req_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_data         (rsp_data),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // 20 ns period
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run bound
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("tb_wake_light_ramp_controller: errors");
         $finish;
      end
   end

   // result side: random stall before each transfer, or a long hold-off on
   // request so the single result register fills and req_ready drops
   initial begin
      int stall;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_OFF_CYCLES) @(negedge clock);
         end else begin
            stall = burst ? 0 : $urandom_range(5, 0);
            if (stall > 0) begin
               rsp_ready <= 1'b0;
               repeat (stall) @(negedge clock);
            end
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
         board.check_light(rsp_data);
         @(negedge clock);
      end
   end

   // offer one epoch and hold it until the transfer; starts and ends at a
   // falling edge, and leaves valid high so a back-to-back epoch needs no toggle
   task automatic offer_epoch(input req_type epoch);
      int gap;
      gap = burst ? 0 : $urandom_range(5, 0);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= epoch;
      do @(posedge clock); while (!req_ready);
      board.note_epoch(epoch);
      epochs_sent++;
      @(negedge clock);
   endtask

   // stop offering and let every expected light come back
   task automatic drain();
      req_valid <= 1'b0;
      while (board.pending() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_BITS-1:0] index,
                                 input logic [CSR_DATA_BITS-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_write_data   <= data;
      board.set_register(index, data);
      @(negedge clock);
   endtask

   task automatic load_settings(input cfg_type values);
      settings = values;
      write_register(CSR_HIGH_THRESHOLD, 16'(values.high_motion_threshold));
      write_register(CSR_LOW_THRESHOLD,  16'(values.low_motion_threshold));
      write_register(CSR_START_LEVEL,    16'(values.start_brightness));
      write_register(CSR_STEP,           16'(values.brightness_step));
      write_register(CSR_CEILING,        16'(values.brightness_ceiling));
      write_register(CSR_RAMP_INTERVAL,  values.ramp_interval);
      write_register(CSR_SETTLE_COUNT,   16'(values.settle_epoch_count));
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // register sets per phase: extremes first, then random ones
   function automatic cfg_type settings_for(int phase);
      cfg_type values;
      case (phase)
         2: values = '0;
         3: values = '1;
         4: begin
            // everything nonzero is high and everything below the top is low
            values = '1;
            values.high_motion_threshold = '0;
         end
         5: begin
            // start above ceiling, zero step, zero interval, zero settle count
            values.high_motion_threshold = RESET_HIGH_THRESHOLD;
            values.low_motion_threshold  = RESET_LOW_THRESHOLD;
            values.start_brightness      = 8'd200;
            values.brightness_step       = 8'd0;
            values.brightness_ceiling    = 8'd100;
            values.ramp_interval         = 16'd0;
            values.settle_epoch_count    = 8'd0;
         end
         default: begin
            values.high_motion_threshold = 12'($urandom_range(800, 100));
            values.low_motion_threshold  = 12'($urandom_range(200, 0));
            values.start_brightness      = 8'($urandom());
            values.brightness_step       = 8'($urandom_range(40, 0));
            values.brightness_ceiling    = 8'($urandom());
            values.ramp_interval         = 16'($urandom_range(120, 0));
            values.settle_epoch_count    = 8'($urandom_range(6, 0));
         end
      endcase
      return values;
   endfunction

   function automatic req_type fixed_epoch(logic [1:0] stage, logic monitoring,
                                           logic [11:0] motion, logic [31:0] seconds);
      req_type epoch;
      epoch.sleep_stage     = stage;
      epoch.monitoring_mode = monitoring;
      epoch.motion_level    = motion;
      epoch.time_seconds    = seconds;
      return epoch;
   endfunction

   // random epoch whose motion lands in the asked band; now and then the band
   // is ignored and the clock jumps, to break up well-formed sequences
   function automatic req_type shape_epoch(logic [1:0] stage, logic monitoring,
                                           motion_kind_type kind);
      req_type         epoch;
      motion_kind_type pick;
      pick = ($urandom_range(15, 0) == 0) ? MOTION_ANY : kind;
      if ($urandom_range(39, 0) == 0)
         epoch_time = $urandom();
      else
         epoch_time = epoch_time + $urandom_range(2 * 32'(settings.ramp_interval) + 4, 0);
      case (pick)
         MOTION_LOW:
            epoch.motion_level = (settings.low_motion_threshold == 0) ? 12'd0 :
               12'($urandom_range(settings.low_motion_threshold - 1, 0));
         MOTION_HIGH:
            epoch.motion_level = (settings.high_motion_threshold == 12'hFFF) ? 12'hFFF :
               12'($urandom_range(4095, settings.high_motion_threshold + 1));
         MOTION_MID:
            epoch.motion_level = 12'($urandom_range(settings.low_motion_threshold,
                                                    settings.high_motion_threshold));
         default: epoch.motion_level = 12'($urandom());
      endcase
      epoch.sleep_stage     = stage;
      epoch.monitoring_mode = monitoring;
      epoch.time_seconds    = epoch_time;
      return epoch;
   endfunction

   // sleep, wake on a motion rise, ramp, return, second rise, settle
   task automatic wake_episode(input int ramp_epochs, input bit flicker);
      int              n;
      int              i;
      motion_kind_type kind;
      epoch_time = $urandom();
      n = $urandom_range(4, 1);
      repeat (n)
         offer_epoch(shape_epoch($urandom_range(1, 0) ? STAGE_NREM : STAGE_REM, 1'b0,
                                 MOTION_LOW));
      if ($urandom_range(3, 0) == 0)
         offer_epoch(shape_epoch(2'($urandom()), 1'b1, MOTION_HIGH));
      else
         offer_epoch(shape_epoch(STAGE_WAKE, 1'b0, MOTION_HIGH));
      // restless ramp: with flicker, alternating mid and high piles up rises without a low
      for (i = 0; i < ramp_epochs; i++) begin
         if (flicker)
            kind = (i % 2 == 1) ? MOTION_HIGH : MOTION_MID;
         else
            kind = ($urandom_range(3, 0) == 0) ? MOTION_HIGH : MOTION_MID;
         offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()), kind));
      end
      offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()), MOTION_LOW));
      n = $urandom_range(3, 0);
      repeat (n)
         offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()),
                                 $urandom_range(1, 0) ? MOTION_LOW : MOTION_MID));
      offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()), MOTION_HIGH));
      n = int'(settings.settle_epoch_count) + $urandom_range(2, 0);
      repeat (n)
         offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()), MOTION_LOW));
   endtask

   task automatic run_random(input int budget, input bit restless);
      int first;
      int n;
      bit held;
      first = epochs_sent;
      held  = 1'b0;
      if (restless) begin
         burst = 1'b0;
         wake_episode(540, 1'b1);
      end
      while (epochs_sent - first < budget) begin
         // one long hold-off per phase while epochs keep coming
         if (!held && epochs_sent - first >= 40) begin
            hold_request = 1'b1;
            held = 1'b1;
         end
         burst = ($urandom_range(3, 0) == 0);
         if ($urandom_range(4, 0) != 0) begin
            wake_episode($urandom_range(12, 0), 1'b0);
         end else begin
            n = $urandom_range(10, 1);
            repeat (n)
               offer_epoch(shape_epoch(2'($urandom()), 1'($urandom()), MOTION_ANY));
         end
      end
      burst = 1'b0;
   endtask

   // reset values: high 320, low 80, start 20, step 5, ceiling 80,
   // interval 30, settle 2
   task automatic run_directed();
      // wake from nrem with a rise, ramp, return, second rise, settle
      offer_epoch(fixed_epoch(STAGE_NREM,    1'b0, 12'd0,    32'd1000));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b0, 12'hFFF,  32'd1005));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b0, 12'd200,  32'd1010));
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b0, 12'd321,  32'd1034));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b1, 12'd320,  32'd1035));
      offer_epoch(fixed_epoch(STAGE_REM,     1'b0, 12'd79,   32'd1300));
      offer_epoch(fixed_epoch(STAGE_NREM,    1'b0, 12'd80,   32'd1301));
      offer_epoch(fixed_epoch(STAGE_NREM,    1'b0, 12'hFFF,  32'd1302));
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b0, 12'd0,    32'd1303));
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b0, 12'd0,    32'd1304));
      // wake from rem, ramp across the timestamp wrap
      offer_epoch(fixed_epoch(STAGE_REM,     1'b0, 12'd0,    32'd1305));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b0, 12'hFFF,  32'hFFFF_FFF0));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b1, 12'hFFF,  32'hFFFF_FFF5));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b1, 12'd100,  32'h0000_000E));
      offer_epoch(fixed_epoch(STAGE_NREM,    1'b0, 12'd0,    32'h0000_000E));
      offer_epoch(fixed_epoch(STAGE_REM,     1'b1, 12'd150,  32'h0000_0072));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b0, 12'd4000, 32'h0000_0080));
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b1, 12'd0,    32'h8000_0000));
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b1, 12'd0,    32'h8000_0001));
      // rise with no wake and no monitoring stays idle
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b0, 12'hFFF,  32'h8000_0002));
      offer_epoch(fixed_epoch(STAGE_WAKE,    1'b0, 12'd0,    32'h8000_0003));
      // monitoring turns on from unknown stage on a rise
      offer_epoch(fixed_epoch(STAGE_UNKNOWN, 1'b1, 12'd321,  32'hFFFF_FFFF));
      offer_epoch(fixed_epoch(STAGE_REM,     1'b0, 12'd0,    32'h0000_0000));
   endtask

   initial begin
      int phase;
      board = new();
      settings = board.regs;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      run_directed();
      drain();
      for (phase = 1; phase <= PHASE_COUNT; phase++) begin
         if (phase > 1)
            load_settings(settings_for(phase));
         run_random(PHASE_EPOCHS, phase == 1);
         drain();
      end
      if (board.mismatches == 0 && board.pending() == 0)
         $display("tb_wake_light_ramp_controller: clean");
      else
         $display("tb_wake_light_ramp_controller: errors");
      $finish;
   end

endmodule
